/* src/yuy2_pair_to_rgb_defines.svh */
// Assertion macros shared by the yuy2_pair_to_rgb RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef YUY2_PAIR_TO_RGB_DEFINES_SVH
`define YUY2_PAIR_TO_RGB_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
`define YP2R_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define YP2R_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/yp2r_pkg.sv */
// Shared widths, coefficients and types for the YUY2 pair to RGB converter.
// No dependencies; used by every module of the block.
package yp2r_pkg;

    localparam int DATA_W      = 8;
    localparam int NUM_W       = 24;  // signed numerator of any channel
    localparam int QN_W        = 22;  // non-negative numerator below saturation
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 36;
    localparam int PROD_W      = QN_W + RECIP_W;
    localparam int PY_W        = 22;  // 11644 * Y
    localparam int PCR_W       = 22;  // 15938 * Cr
    localparam int PCB_W       = 23;  // 20238 * Cb
    localparam int GY_W        = 23;  // 19837 * Y
    localparam int PRB_W       = 21;  // 5094 * R and 1942 * B
    localparam int STAGES      = 6;   // register stages per lane

    localparam logic [13:0] K_Y_RB = 14'd11644;
    localparam logic [13:0] K_CR   = 14'd15938;
    localparam logic [14:0] K_CB   = 15'd20238;
    localparam logic [14:0] K_Y_G  = 15'd19837;
    localparam logic [12:0] K_R_G  = 13'd5094;
    localparam logic [10:0] K_B_G  = 11'd1942;

    localparam logic signed [NUM_W-1:0] OFS_R = NUM_W'(2221300);
    localparam logic signed [NUM_W-1:0] OFS_B = NUM_W'(2771300);
    localparam logic signed [NUM_W-1:0] OFS_G = NUM_W'(311710);

    // Quotients of 256 or more saturate, so anything at or above 256 * 10000 is full scale.
    localparam logic signed [NUM_W-1:0] SAT_NUM = NUM_W'(2560000);

    // ceil(2^36 / 10000): exact floor division for every numerator below 2^22.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(6871948);

    localparam logic [DATA_W-1:0] CH_MAX = 8'hFF;

    typedef struct packed {
        logic [DATA_W-1:0] blue;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] red;
    } pixel_t;

endpackage

/* src/yp2r_clampdiv.sv */
// Two-stage clamp and divide by 10000 of a signed channel numerator.
// Depends on yp2r_pkg.
module yp2r_clampdiv
    import yp2r_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    output logic [DATA_W-1:0]       quot
);

    logic [QN_W-1:0]   numc_reg;
    logic [QN_W-1:0]   numc_next;
    logic              sat_a_reg;
    logic              sat_a_next;
    logic [PROD_W-1:0] prod_reg;
    logic              sat_b_reg;

    // Negative numerators give zero, large ones saturate; the rest divide exactly.
    always_comb
    begin
        if (num >= SAT_NUM)
        begin
            sat_a_next = 1'b1;
            numc_next  = '0;
        end
        else if (num < 0)
        begin
            sat_a_next = 1'b0;
            numc_next  = '0;
        end
        else
        begin
            sat_a_next = 1'b0;
            numc_next  = num[QN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numc_reg  <= numc_next;
            sat_a_reg <= sat_a_next;
            prod_reg  <= PROD_W'(numc_reg) * PROD_W'(RECIP);
            sat_b_reg <= sat_a_reg;
        end
    end

    assign quot = sat_b_reg ? CH_MAX : prod_reg[RECIP_SHIFT+DATA_W-1:RECIP_SHIFT];

endmodule

/* src/yp2r_lane.sv */
// One pixel conversion lane: luma plus shared chroma to a clamped RGB pixel.
// Depends on yp2r_pkg and yp2r_clampdiv.
module yp2r_lane
    import yp2r_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] luma,
    input  logic [DATA_W-1:0] cb,
    input  logic [DATA_W-1:0] cr,
    output pixel_t            pix
);

    logic [PY_W-1:0]   py_reg;
    logic [PCR_W-1:0]  pcr_reg;
    logic [PCB_W-1:0]  pcb_reg;
    logic [GY_W-1:0]   gy_reg;
    logic [GY_W-1:0]   gy_d1_reg;
    logic [GY_W-1:0]   gy_d2_reg;
    logic [GY_W-1:0]   gy_s4_reg;
    logic [DATA_W-1:0] red_s4_reg;
    logic [DATA_W-1:0] blue_s4_reg;
    logic [PRB_W-1:0]  pr_reg;
    logic [PRB_W-1:0]  pb_reg;
    logic [DATA_W-1:0] red_d1_reg;
    logic [DATA_W-1:0] blue_d1_reg;
    logic [DATA_W-1:0] red_d2_reg;
    logic [DATA_W-1:0] blue_d2_reg;

    logic signed [NUM_W-1:0] num_red;
    logic signed [NUM_W-1:0] num_blue;
    logic signed [NUM_W-1:0] num_green;
    logic [DATA_W-1:0]       red_q;
    logic [DATA_W-1:0]       blue_q;
    logic [DATA_W-1:0]       green_q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg      <= PY_W'(luma) * PY_W'(K_Y_RB);
            pcr_reg     <= PCR_W'(cr) * PCR_W'(K_CR);
            pcb_reg     <= PCB_W'(cb) * PCB_W'(K_CB);
            gy_reg      <= GY_W'(luma) * GY_W'(K_Y_G);
            gy_d1_reg   <= gy_reg;
            gy_d2_reg   <= gy_d1_reg;
            gy_s4_reg   <= gy_d2_reg;
            red_s4_reg  <= red_q;
            blue_s4_reg <= blue_q;
            pr_reg      <= PRB_W'(red_q) * PRB_W'(K_R_G);
            pb_reg      <= PRB_W'(blue_q) * PRB_W'(K_B_G);
            red_d1_reg  <= red_s4_reg;
            blue_d1_reg <= blue_s4_reg;
            red_d2_reg  <= red_d1_reg;
            blue_d2_reg <= blue_d1_reg;
        end
    end

    assign num_red  = signed'(NUM_W'(py_reg)) + signed'(NUM_W'(pcr_reg)) - OFS_R;
    assign num_blue = signed'(NUM_W'(py_reg)) + signed'(NUM_W'(pcb_reg)) - OFS_B;

    // Green is formed from the red and blue values after clamping.
    assign num_green = signed'(NUM_W'(gy_s4_reg)) - OFS_G
                       - signed'(NUM_W'(pr_reg)) - signed'(NUM_W'(pb_reg));

    yp2r_clampdiv u_div_red
    (
        .clk  (clk),
        .en   (en),
        .num  (num_red),
        .quot (red_q)
    );

    yp2r_clampdiv u_div_blue
    (
        .clk  (clk),
        .en   (en),
        .num  (num_blue),
        .quot (blue_q)
    );

    yp2r_clampdiv u_div_green
    (
        .clk  (clk),
        .en   (en),
        .num  (num_green),
        .quot (green_q)
    );

    assign pix.blue  = blue_d2_reg;
    assign pix.green = green_q;
    assign pix.red   = red_d2_reg;

endmodule

/* src/yuy2_pair_to_rgb.sv */
// YUY2 macropixel to RGB pair converter.
// Input channel: in_valid / in_stall with luma_first, chroma_blue, luma_second,
// chroma_red and end_of_frame; one item is one macropixel.
// Output channel: out_valid / out_stall with two RGB pixels and frame_done, one
// item out for every item in.
// Each macropixel runs through two identical lanes, one per luma sample, which
// share the chroma bytes; the output register joins the two pixels.
// Throughput is one item per cycle when nothing stalls, set by the fully pipelined
// lanes: six constant multiplies and three reciprocal multiplies per lane, each
// given a register. When out_stall holds a waiting item the whole pipeline freezes
// and in_stall is raised in the same cycle; nothing is dropped, and the flow
// resumes at full rate once the item is taken.
// Reset clears the valid bits of the pipeline and the output; data registers
// are not reset. No configuration is needed and no clearing pass is run.
// Depends on yp2r_pkg, yp2r_lane and yp2r_clampdiv.
`include "yuy2_pair_to_rgb_defines.svh"

module yuy2_pair_to_rgb
    import yp2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] luma_first,
    input  logic [DATA_W-1:0] chroma_blue,
    input  logic [DATA_W-1:0] luma_second,
    input  logic [DATA_W-1:0] chroma_red,
    input  logic              end_of_frame,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] blue_first,
    output logic [DATA_W-1:0] green_first,
    output logic [DATA_W-1:0] red_first,
    output logic [DATA_W-1:0] blue_second,
    output logic [DATA_W-1:0] green_second,
    output logic [DATA_W-1:0] red_second,
    output logic              frame_done
);

    localparam int LAST = STAGES - 1;

    logic              en;
    logic [LAST:0]     vld_reg;
    logic [LAST:0]     eof_reg;
    logic              out_valid_reg;
    pixel_t            pix_first;
    pixel_t            pix_second;
    pixel_t            first_reg;
    pixel_t            second_reg;
    logic              done_reg;

    // The pipeline moves only while the output register can take a new item.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    yp2r_lane u_lane_first
    (
        .clk  (clk),
        .en   (en),
        .luma (luma_first),
        .cb   (chroma_blue),
        .cr   (chroma_red),
        .pix  (pix_first)
    );

    yp2r_lane u_lane_second
    (
        .clk  (clk),
        .en   (en),
        .luma (luma_second),
        .cb   (chroma_blue),
        .cr   (chroma_red),
        .pix  (pix_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAST-1:0], in_valid};
            out_valid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eof_reg    <= {eof_reg[LAST-1:0], end_of_frame};
            first_reg  <= pix_first;
            second_reg <= pix_second;
            done_reg   <= eof_reg[LAST];
        end
    end

    assign out_valid    = out_valid_reg;
    assign blue_first   = first_reg.blue;
    assign green_first  = first_reg.green;
    assign red_first    = first_reg.red;
    assign blue_second  = second_reg.blue;
    assign green_second = second_reg.green;
    assign red_second   = second_reg.red;
    assign frame_done   = done_reg;

    `YP2R_ASSERT_NXT(a_accept_enters_pipe, in_valid && !in_stall, vld_reg[0], "accepted item did not enter the pipeline")
    `YP2R_ASSERT_NXT(a_stall_freezes_pipe, out_valid_reg && out_stall, vld_reg == $past(vld_reg), "pipeline moved while the output was held")
    `YP2R_ASSERT_IMP(a_output_from_pipe, $rose(out_valid_reg), $past(vld_reg[LAST]), "output became valid without an item in the last stage")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for yuy2_pair_to_rgb: drives YUY2 macropixels through the
// valid/stall input channel and compares every RGB pair with a local BT.601 predictor.
// Depends on yp2r_pkg for widths and pixel_t, and on the block's RTL.
module tb_top
    import yp2r_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 40000;
    localparam int IDLE_PCT    = 18;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [DATA_W-1:0] y0;
        logic [DATA_W-1:0] cb;
        logic [DATA_W-1:0] y1;
        logic [DATA_W-1:0] cr;
        logic              eof;
    } yuy2_item_t;

    typedef struct packed {
        pixel_t first;
        pixel_t second;
        logic   done;
    } rgb_pair_t;

    // Pixels are written {blue, green, red}; rows with has_exp clear are predicted.
    typedef struct packed {
        logic [DATA_W-1:0] y0;
        logic [DATA_W-1:0] cb;
        logic [DATA_W-1:0] y1;
        logic [DATA_W-1:0] cr;
        logic              eof;
        logic              has_exp;
        pixel_t            exp0;
        pixel_t            exp1;
    } stim_row_t;

    stim_row_t directed_rows [20] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 24'h000000, 24'h000000},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF},
        '{8'd0,   8'd128, 8'd255, 8'd128, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd255, 8'd128, 8'd0,   8'd128, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd128, 8'd0,   8'd128, 8'd0,   1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd128, 8'd255, 8'd128, 8'd255, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd128, 8'd255, 8'd128, 8'd0,   1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd16,  8'd128, 8'd235, 8'd128, 1'b1, 1'b0, 24'h000000, 24'h000000},
        '{8'd235, 8'd16,  8'd16,  8'd240, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd81,  8'd90,  8'd145, 8'd240, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd41,  8'd240, 8'd112, 8'd110, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd170, 8'd85,  8'd85,  8'd170, 1'b1, 1'b0, 24'h000000, 24'h000000},
        '{8'd85,  8'd170, 8'd170, 8'd85,  1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd1,   8'd254, 8'd254, 8'd1,   1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd191, 8'd127, 8'd128, 8'd128, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd255, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd0,   8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 24'h000000, 24'h000000},
        '{8'd255, 8'd128, 8'd255, 8'd128, 1'b0, 1'b0, 24'h000000, 24'h000000},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 24'h000000, 24'h000000}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [DATA_W-1:0] luma_first;
    logic [DATA_W-1:0] chroma_blue;
    logic [DATA_W-1:0] luma_second;
    logic [DATA_W-1:0] chroma_red;
    logic              end_of_frame;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] blue_first;
    logic [DATA_W-1:0] green_first;
    logic [DATA_W-1:0] red_first;
    logic [DATA_W-1:0] blue_second;
    logic [DATA_W-1:0] green_second;
    logic [DATA_W-1:0] red_second;
    logic              frame_done;

    logic        hold_go;
    logic        calm_mode;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    rgb_pair_t   pending_pairs [$];

    yuy2_pair_to_rgb DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .luma_first   (luma_first),
        .chroma_blue  (chroma_blue),
        .luma_second  (luma_second),
        .chroma_red   (chroma_red),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .blue_first   (blue_first),
        .green_first  (green_first),
        .red_first    (red_first),
        .blue_second  (blue_second),
        .green_second (green_second),
        .red_second   (red_second),
        .frame_done   (frame_done)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Negative numerators give zero; quotients above full scale saturate.
    function automatic logic [DATA_W-1:0] clamp_channel(input int num);
        int q;
        if (num < 0)
            return '0;
        q = num / 10000;
        if (q > 255)
            return CH_MAX;
        return DATA_W'(q);
    endfunction

    function automatic pixel_t pixel_from_yuv(input logic [DATA_W-1:0] y,
                                              input logic [DATA_W-1:0] cb,
                                              input logic [DATA_W-1:0] cr);
        pixel_t p;
        int     ly;
        ly      = 11644 * int'(y);
        p.red   = clamp_channel(ly + 15938 * int'(cr) - 2221300);
        p.blue  = clamp_channel(ly + 20238 * int'(cb) - 2771300);
        // Green is derived from the red and blue values after clamping.
        p.green = clamp_channel(19837 * int'(y) - 311710
                                - 5094 * int'(p.red) - 1942 * int'(p.blue));
        return p;
    endfunction

    function automatic rgb_pair_t convert_pair(input yuy2_item_t item);
        rgb_pair_t r;
        r.first  = pixel_from_yuv(item.y0, item.cb, item.cr);
        r.second = pixel_from_yuv(item.y1, item.cb, item.cr);
        r.done   = item.eof;
        return r;
    endfunction

    // Extremes and values close to the clamping thresholds turn up more often than
    // a flat spread would give them.
    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return DATA_W'($urandom_range(15));
            3: return DATA_W'(240 + $urandom_range(15));
            default: return DATA_W'($urandom_range(255));
        endcase
    endfunction

    function automatic yuy2_item_t rand_item();
        yuy2_item_t item;
        item.y0  = pick_byte();
        item.cb  = pick_byte();
        item.y1  = pick_byte();
        item.cr  = pick_byte();
        item.eof = ($urandom_range(15) == 0);
        return item;
    endfunction

    task automatic report_error(input string what, input rgb_pair_t want,
                                input rgb_pair_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s: exp %0d/%0d/%0d %0d/%0d/%0d eof %0b, got %0d/%0d/%0d %0d/%0d/%0d eof %0b",
                     what,
                     want.first.blue, want.first.green, want.first.red,
                     want.second.blue, want.second.green, want.second.red, want.done,
                     got.first.blue, got.first.green, got.first.red,
                     got.second.blue, got.second.green, got.second.red, got.done);
    endtask

    // Offers one item and holds it until accepted; the expectation is queued at the
    // accepting edge, always ahead of the matching result.
    task automatic offer_pair(input yuy2_item_t item, input bit has_exp,
                              input rgb_pair_t typed_exp, input bit no_gaps);
        int gaps;
        gaps = 0;
        if (!no_gaps)
            while ($urandom_range(99) < IDLE_PCT)
                gaps++;
        if (gaps > 0)
        begin
            in_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        in_valid     <= 1'b1;
        luma_first   <= item.y0;
        chroma_blue  <= item.cb;
        luma_second  <= item.y1;
        chroma_red   <= item.cr;
        end_of_frame <= item.eof;
        do
            @(posedge clk);
        while (in_stall);
        pending_pairs.push_back(has_exp ? typed_exp : convert_pair(item));
    endtask

    task automatic wait_drain();
        do
            @(posedge clk);
        while (pending_pairs.size() != 0);
    endtask

    initial
    begin : stimulus
        yuy2_item_t item;
        rgb_pair_t  typed;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        luma_first   = '0;
        chroma_blue  = '0;
        luma_second  = '0;
        chroma_red   = '0;
        end_of_frame = 1'b0;
        hold_go      = 1'b0;
        calm_mode    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            item.y0      = directed_rows[i].y0;
            item.cb      = directed_rows[i].cb;
            item.y1      = directed_rows[i].y1;
            item.cr      = directed_rows[i].cr;
            item.eof     = directed_rows[i].eof;
            typed.first  = directed_rows[i].exp0;
            typed.second = directed_rows[i].exp1;
            typed.done   = directed_rows[i].eof;
            offer_pair(item, directed_rows[i].has_exp, typed, 1'b0);
        end

        // Back-to-back items with the receiver always ready.
        calm_mode <= 1'b1;
        repeat (60) offer_pair(rand_item(), 1'b0, '0, 1'b1);

        // The receiver holds off while items keep coming, so the pipeline fills.
        calm_mode <= 1'b0;
        hold_go   <= 1'b1;
        repeat (40) offer_pair(rand_item(), 1'b0, '0, 1'b1);

        in_valid <= 1'b0;
        wait_drain();

        repeat (300) offer_pair(rand_item(), 1'b0, '0, 1'b0);
        in_valid <= 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_pairs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (calm_mode)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : result_check
        rgb_pair_t got;
        rgb_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.first.blue   = blue_first;
            got.first.green  = green_first;
            got.first.red    = red_first;
            got.second.blue  = blue_second;
            got.second.green = green_second;
            got.second.red   = red_second;
            got.done         = frame_done;
            if (pending_pairs.size() == 0)
                report_error("unexpected item", '0, got);
            else
            begin
                want = pending_pairs.pop_front();
                if (got.first !== want.first || got.second !== want.second
                    || got.done !== want.done)
                    report_error("mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
